// ===== rtl/srs_pkg.sv =====
// Shared constants, codes and types of the sparse row-indexed store.
package srs_pkg;

    // Storage sizes
    localparam int MAX_DIM     = 1024;
    localparam int STORE_DEPTH = 8192;

    // Widths that follow from the storage sizes
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int N_W    = $clog2(MAX_DIM + 1);

    // Fixed field widths
    localparam int FUNC_W    = 3;
    localparam int COORD_W   = 10;
    localparam int ROW_W     = COORD_W + 1;
    localparam int VAL_W     = 64;
    localparam int STATUS_W  = 3;
    localparam int DIM_W     = 11;
    localparam int CAPCFG_W  = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam int DIM_RESET = 1024;
    localparam int CAP_RESET = 8191;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR    = 3'd0,
        FN_NEW_ROW  = 3'd1,
        FN_APPEND   = 3'd2,
        FN_SET_DIAG = 3'd3,
        FN_CLOSE    = 3'd4,
        FN_READ     = 3'd5,
        FN_WRITE    = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 3'd0,
        STS_RANGE  = 3'd1,
        STS_ORDER  = 3'd2,
        STS_ABSENT = 3'd3,
        STS_OPEN   = 3'd4,
        STS_FULL   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLOSE,
        S_PTR_LO,
        S_PTR_HI,
        S_SCAN,
        S_VAL
    } state_t;

endpackage

// ===== rtl/srs_req_if.sv =====
// Request channel of the sparse row-indexed store.
interface srs_req_if;
    logic                           valid;
    logic                           ready;
    logic [srs_pkg::FUNC_W-1:0]     func;
    logic [srs_pkg::COORD_W-1:0]    row_index;
    logic [srs_pkg::COORD_W-1:0]    col_index;
    logic [srs_pkg::VAL_W-1:0]      data_value;

    modport source (output valid, func, row_index, col_index, data_value, input ready);
    modport sink   (input valid, func, row_index, col_index, data_value, output ready);
endinterface

// ===== rtl/srs_rsp_if.sv =====
// Response channel of the sparse row-indexed store.
interface srs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [srs_pkg::VAL_W-1:0]      read_value;
    logic [srs_pkg::STATUS_W-1:0]   status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== rtl/sparse_row_indexed_store.sv =====
// Sparse row-indexed matrix store: a sequencer around an index memory and a value memory.
// Clear, new row, append, set diagonal and unknown codes answer straight from idle; a diagonal
// read passes through S_VAL; an off-diagonal read or write passes through S_PTR_LO, S_PTR_HI
// and S_SCAN, which walks the row slots (one index memory read per slot), and on a read hit
// through S_VAL; close fills the row pointers in S_CLOSE from first unbuilt row r up to slot n.
// One item in flight; the next beat is taken once the result is gone. Reset, clear and any
// register write start a pass zeroing the diagonal; no item is accepted during it.
module sparse_row_indexed_store (
    input  logic                              clk,
    input  logic                              rst_n,
    srs_req_if.sink                           req,
    srs_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]         cfg_data
);

    // Effective dimension: clamp to 1..MAX_DIM and below the store depth.
    function automatic logic [srs_pkg::N_W-1:0] eff_dim(input logic [srs_pkg::DIM_W-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        if (v < 32'd1)
        begin
            v = 32'd1;
        end
        if (v > 32'(srs_pkg::MAX_DIM))
        begin
            v = 32'(srs_pkg::MAX_DIM);
        end
        if (v > 32'(srs_pkg::STORE_DEPTH - 1))
        begin
            v = 32'(srs_pkg::STORE_DEPTH - 1);
        end
        return srs_pkg::N_W'(v);
    endfunction

    // Effective capacity: clamp to n..STORE_DEPTH-1.
    function automatic logic [srs_pkg::ADDR_W-1:0] eff_cap(
        input logic [srs_pkg::CAPCFG_W-1:0] c,
        input logic [srs_pkg::N_W-1:0]      nd
    );
        logic [31:0] v;
        v = 32'(c);
        if (v < 32'(nd))
        begin
            v = 32'(nd);
        end
        if (v > 32'(srs_pkg::STORE_DEPTH - 1))
        begin
            v = 32'(srs_pkg::STORE_DEPTH - 1);
        end
        return srs_pkg::ADDR_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Memories. The index memory holds the row pointers in slots 0..n and
    // the column of each off-diagonal entry in slots n+1 upwards. The value
    // memory holds the diagonal in slots 0..n-1 and the off-diagonal values
    // next to their columns. Both are single ported, read data registered.
    // ------------------------------------------------------------------
    logic [srs_pkg::IDX_W-1:0]  idx_mem [srs_pkg::STORE_DEPTH];
    logic [srs_pkg::VAL_W-1:0]  val_mem [srs_pkg::STORE_DEPTH];

    logic                       idx_en;
    logic                       idx_we;
    logic [srs_pkg::ADDR_W-1:0] idx_addr;
    logic [srs_pkg::IDX_W-1:0]  idx_wdata;
    logic [srs_pkg::IDX_W-1:0]  idx_rdata_reg;

    logic                       val_en;
    logic                       val_we;
    logic [srs_pkg::ADDR_W-1:0] val_addr;
    logic [srs_pkg::VAL_W-1:0]  val_wdata;
    logic [srs_pkg::VAL_W-1:0]  val_rdata_reg;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    srs_pkg::state_t                  state_reg,     state_next;
    logic [srs_pkg::DIM_W-1:0]        dim_reg,       dim_next;
    logic [srs_pkg::CAPCFG_W-1:0]     capcfg_reg,    capcfg_next;
    logic signed [srs_pkg::ROW_W-1:0] build_row_reg, build_row_next;
    logic signed [srs_pkg::ROW_W-1:0] last_col_reg,  last_col_next;
    logic [srs_pkg::ADDR_W-1:0]       fill_reg,      fill_next;
    logic                             closed_reg,    closed_next;
    logic [srs_pkg::COORD_W-1:0]      clr_k_reg,     clr_k_next;
    logic [srs_pkg::N_W-1:0]          close_k_reg,   close_k_next;
    logic                             cmp_valid_reg, cmp_valid_next;
    logic                             out_valid_reg, out_valid_next;

    // Operand and walk registers (payload, no reset)
    logic                             op_write_reg,  op_write_next;
    logic [srs_pkg::COORD_W-1:0]      row_reg,       row_next;
    logic [srs_pkg::COORD_W-1:0]      col_reg,       col_next;
    logic [srs_pkg::VAL_W-1:0]        data_reg,      data_next;
    logic [srs_pkg::IDX_W-1:0]        scan_k_reg,    scan_k_next;
    logic [srs_pkg::IDX_W-1:0]        hi_reg,        hi_next;
    logic [srs_pkg::ADDR_W-1:0]       cmp_k_reg,     cmp_k_next;
    logic [srs_pkg::VAL_W-1:0]        out_value_reg, out_value_next;
    srs_pkg::status_t                 out_status_reg, out_status_next;

    // Derived values
    logic [srs_pkg::N_W-1:0]    n;
    logic [srs_pkg::ADDR_W-1:0] cap;
    logic [srs_pkg::N_W-1:0]    open_row;
    logic [srs_pkg::IDX_W-1:0]  fill_p1;
    logic [srs_pkg::IDX_W-1:0]  n_p1;
    logic [srs_pkg::IDX_W-1:0]  cap_p1;
    logic                       req_ready;
    logic                       clear_go;
    logic                       hi_ok;

    assign n        = eff_dim(dim_reg);
    assign cap      = eff_cap(capcfg_reg, n);
    // First row not yet opened; equals n once every row is open.
    assign open_row = srs_pkg::N_W'($unsigned(32'(build_row_reg) + 32'sd1));
    assign fill_p1  = srs_pkg::IDX_W'(32'(fill_reg) + 32'd1);
    assign n_p1     = srs_pkg::IDX_W'(32'(n) + 32'd1);
    assign cap_p1   = srs_pkg::IDX_W'(32'(cap) + 32'd1);
    // Pointer of row r+1 is written once row r+1 is open or the matrix is closed;
    // an unwritten pointer is not used: S_PTR_HI ends the row's scan at slot 0, which gives an empty row.
    assign hi_ok    = closed_reg || ($signed(32'(row_reg)) < 32'(build_row_reg));

    assign req.ready      = req_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state, memory controls and result beat
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        dim_next        = dim_reg;
        capcfg_next     = capcfg_reg;
        build_row_next  = build_row_reg;
        last_col_next   = last_col_reg;
        fill_next       = fill_reg;
        closed_next     = closed_reg;
        clr_k_next      = clr_k_reg;
        close_k_next    = close_k_reg;
        cmp_valid_next  = cmp_valid_reg;
        op_write_next   = op_write_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        data_next       = data_reg;
        scan_k_next     = scan_k_reg;
        hi_next         = hi_reg;
        cmp_k_next      = cmp_k_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        // Drop the result beat once taken
        out_valid_next  = out_valid_reg && !rsp.ready;

        idx_en    = 1'b0;
        idx_we    = 1'b0;
        idx_addr  = '0;
        idx_wdata = '0;
        val_en    = 1'b0;
        val_we    = 1'b0;
        val_addr  = '0;
        val_wdata = '0;
        req_ready = 1'b0;
        clear_go  = 1'b0;

        case (state_reg)
            srs_pkg::S_CLEAR:
            begin
                // Zero one diagonal slot per cycle
                val_en   = 1'b1;
                val_we   = 1'b1;
                val_addr = srs_pkg::ADDR_W'(clr_k_reg);
                if (32'(clr_k_reg) + 32'd1 >= 32'(n))
                begin
                    state_next = srs_pkg::S_IDLE;
                end
                else
                begin
                    clr_k_next = clr_k_reg + 1'b1;
                end
            end

            srs_pkg::S_IDLE:
            begin
                req_ready = !out_valid_reg;
                if (req.valid && !out_valid_reg)
                begin
                    row_next        = req.row_index;
                    col_next        = req.col_index;
                    data_next       = req.data_value;
                    out_value_next  = '0;
                    out_status_next = srs_pkg::STS_OK;
                    out_valid_next  = 1'b1;
                    case (srs_pkg::func_t'(req.func))
                        srs_pkg::FN_CLEAR:
                        begin
                            clear_go = 1'b1;
                        end

                        srs_pkg::FN_NEW_ROW:
                        begin
                            if (32'(open_row) >= 32'(n))
                            begin
                                out_status_next = srs_pkg::STS_RANGE;
                            end
                            else
                            begin
                                idx_en         = 1'b1;
                                idx_we         = 1'b1;
                                idx_addr       = srs_pkg::ADDR_W'(open_row);
                                idx_wdata      = fill_p1;
                                build_row_next = srs_pkg::ROW_W'(32'(build_row_reg) + 32'sd1);
                                last_col_next  = '1;
                            end
                        end

                        srs_pkg::FN_APPEND:
                        begin
                            if (32'(req.col_index) >= 32'(n))
                            begin
                                out_status_next = srs_pkg::STS_RANGE;
                            end
                            else if (32'(req.col_index) == 32'(build_row_reg))
                            begin
                                // Column on the open row's diagonal: store as diagonal
                                val_en    = 1'b1;
                                val_we    = 1'b1;
                                val_addr  = srs_pkg::ADDR_W'(req.col_index);
                                val_wdata = req.data_value;
                            end
                            else if ($signed(32'(req.col_index)) <= 32'(last_col_reg))
                            begin
                                out_status_next = srs_pkg::STS_ORDER;
                            end
                            else if (fill_reg >= cap)
                            begin
                                out_status_next = srs_pkg::STS_FULL;
                            end
                            else
                            begin
                                idx_en        = 1'b1;
                                idx_we        = 1'b1;
                                idx_addr      = srs_pkg::ADDR_W'(fill_p1);
                                idx_wdata     = srs_pkg::IDX_W'(req.col_index);
                                val_en        = 1'b1;
                                val_we        = 1'b1;
                                val_addr      = srs_pkg::ADDR_W'(fill_p1);
                                val_wdata     = req.data_value;
                                fill_next     = srs_pkg::ADDR_W'(fill_p1);
                                last_col_next = srs_pkg::ROW_W'(req.col_index);
                            end
                        end

                        srs_pkg::FN_SET_DIAG:
                        begin
                            if (32'(req.row_index) >= 32'(n))
                            begin
                                out_status_next = srs_pkg::STS_RANGE;
                            end
                            else
                            begin
                                val_en    = 1'b1;
                                val_we    = 1'b1;
                                val_addr  = srs_pkg::ADDR_W'(req.row_index);
                                val_wdata = req.data_value;
                            end
                        end

                        srs_pkg::FN_CLOSE:
                        begin
                            out_valid_next = 1'b0;
                            close_k_next   = open_row;
                            state_next     = srs_pkg::S_CLOSE;
                        end

                        srs_pkg::FN_READ,
                        srs_pkg::FN_WRITE:
                        begin
                            op_write_next = (srs_pkg::func_t'(req.func) == srs_pkg::FN_WRITE);
                            if (32'(req.row_index) >= 32'(n) || 32'(req.col_index) >= 32'(n))
                            begin
                                out_status_next = srs_pkg::STS_RANGE;
                            end
                            else if (srs_pkg::func_t'(req.func) == srs_pkg::FN_WRITE &&
                                     32'(build_row_reg) != 32'(n) - 32'd1)
                            begin
                                out_status_next = srs_pkg::STS_OPEN;
                            end
                            else if (req.row_index == req.col_index)
                            begin
                                val_en   = 1'b1;
                                val_addr = srs_pkg::ADDR_W'(req.row_index);
                                if (srs_pkg::func_t'(req.func) == srs_pkg::FN_WRITE)
                                begin
                                    val_we    = 1'b1;
                                    val_wdata = req.data_value;
                                end
                                else
                                begin
                                    out_valid_next = 1'b0;
                                    state_next     = srs_pkg::S_VAL;
                                end
                            end
                            else
                            begin
                                // Fetch the row's start pointer
                                idx_en         = 1'b1;
                                idx_addr       = srs_pkg::ADDR_W'(req.row_index);
                                out_valid_next = 1'b0;
                                state_next     = srs_pkg::S_PTR_LO;
                            end
                        end

                        default:
                        begin
                            // Unused code: report ok, change nothing
                        end
                    endcase
                end
            end

            srs_pkg::S_CLOSE:
            begin
                // Fill trailing row pointers, one per cycle, up to slot n
                idx_en    = 1'b1;
                idx_we    = 1'b1;
                idx_addr  = srs_pkg::ADDR_W'(close_k_reg);
                idx_wdata = fill_p1;
                if (close_k_reg >= n)
                begin
                    build_row_next  = srs_pkg::ROW_W'(32'(n) - 32'd1);
                    closed_next     = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = srs_pkg::STS_OK;
                    state_next      = srs_pkg::S_IDLE;
                end
                else
                begin
                    close_k_next = close_k_reg + 1'b1;
                end
            end

            srs_pkg::S_PTR_LO:
            begin
                // Start pointer arrives; never search the pointer slots
                scan_k_next = (idx_rdata_reg < n_p1) ? n_p1 : idx_rdata_reg;
                idx_en      = 1'b1;
                idx_addr    = srs_pkg::ADDR_W'(32'(row_reg) + 32'd1);
                state_next  = srs_pkg::S_PTR_HI;
            end

            srs_pkg::S_PTR_HI:
            begin
                if (!hi_ok)
                begin
                    hi_next = '0;
                end
                else if (idx_rdata_reg > cap_p1)
                begin
                    hi_next = cap_p1;
                end
                else
                begin
                    hi_next = idx_rdata_reg;
                end
                cmp_valid_next = 1'b0;
                state_next     = srs_pkg::S_SCAN;
            end

            srs_pkg::S_SCAN:
            begin
                // Issue one column read per cycle and compare the one returned
                if (cmp_valid_reg && idx_rdata_reg == srs_pkg::IDX_W'(col_reg))
                begin
                    val_en         = 1'b1;
                    val_addr       = cmp_k_reg;
                    cmp_valid_next = 1'b0;
                    if (op_write_reg)
                    begin
                        val_we          = 1'b1;
                        val_wdata       = data_reg;
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = srs_pkg::STS_OK;
                        state_next      = srs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = srs_pkg::S_VAL;
                    end
                end
                else if (scan_k_reg < hi_reg)
                begin
                    idx_en         = 1'b1;
                    idx_addr       = srs_pkg::ADDR_W'(scan_k_reg);
                    cmp_valid_next = 1'b1;
                    cmp_k_next     = srs_pkg::ADDR_W'(scan_k_reg);
                    scan_k_next    = scan_k_reg + 1'b1;
                end
                else
                begin
                    // Row exhausted: absent entry
                    cmp_valid_next  = 1'b0;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = op_write_reg ? srs_pkg::STS_ABSENT : srs_pkg::STS_OK;
                    state_next      = srs_pkg::S_IDLE;
                end
            end

            srs_pkg::S_VAL:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = val_rdata_reg;
                out_status_next = srs_pkg::STS_OK;
                state_next      = srs_pkg::S_IDLE;
            end

            default:
            begin
                state_next = srs_pkg::S_IDLE;
            end
        endcase

        // Register write: take the new value, then clear as a clear command does
        if (cfg_we)
        begin
            case (cfg_index)
                srs_pkg::CFG_DIMENSION:
                begin
                    dim_next = srs_pkg::DIM_W'(cfg_data);
                end
                srs_pkg::CFG_CAPACITY:
                begin
                    capcfg_next = srs_pkg::CAPCFG_W'(cfg_data);
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we || clear_go)
        begin
            build_row_next = '1;
            last_col_next  = '1;
            fill_next      = srs_pkg::ADDR_W'(eff_dim(dim_next));
            closed_next    = 1'b0;
            clr_k_next     = '0;
            cmp_valid_next = 1'b0;
            state_next     = srs_pkg::S_CLEAR;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srs_pkg::S_CLEAR;
            dim_reg       <= srs_pkg::DIM_W'(srs_pkg::DIM_RESET);
            capcfg_reg    <= srs_pkg::CAPCFG_W'(srs_pkg::CAP_RESET);
            build_row_reg <= '1;
            last_col_reg  <= '1;
            fill_reg      <= srs_pkg::ADDR_W'(eff_dim(srs_pkg::DIM_W'(srs_pkg::DIM_RESET)));
            closed_reg    <= 1'b0;
            clr_k_reg     <= '0;
            close_k_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            capcfg_reg    <= capcfg_next;
            build_row_reg <= build_row_next;
            last_col_reg  <= last_col_next;
            fill_reg      <= fill_next;
            closed_reg    <= closed_next;
            clr_k_reg     <= clr_k_next;
            close_k_reg   <= close_k_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_write_reg   <= op_write_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        data_reg       <= data_next;
        scan_k_reg     <= scan_k_next;
        hi_reg         <= hi_next;
        cmp_k_reg      <= cmp_k_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Index memory
    always_ff @(posedge clk)
    begin
        if (idx_en)
        begin
            if (idx_we)
            begin
                idx_mem[idx_addr] <= idx_wdata;
            end
            else
            begin
                idx_rdata_reg <= idx_mem[idx_addr];
            end
        end
    end

    // Value memory
    always_ff @(posedge clk)
    begin
        if (val_en)
        begin
            if (val_we)
            begin
                val_mem[val_addr] <= val_wdata;
            end
            else
            begin
                val_rdata_reg <= val_mem[val_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap)
        else $error("fill pointer beyond capacity");

    a_closed_all_rows: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (32'(build_row_reg) == 32'(n) - 32'd1))
        else $error("closed matrix with rows still unopened");

    a_beat_only_when_settled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == srs_pkg::S_IDLE || state_reg == srs_pkg::S_CLEAR))
        else $error("result beat shown while an item is still at work");

endmodule
